// ----- rtl/core/blpg_pkg.sv -----
package blpg_pkg;

   localparam int COORD_BITS = 12;
   localparam int COUNT_BITS = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int WIDTH_BITS = 13;
   localparam int PEN_BITS   = 8;
   localparam int ADDR_BITS  = 24;
   localparam int CSR_ABITS  = 3;
   localparam int CSR_DBITS  = 32;

   localparam logic [1:0] ACT_MOVE   = 2'd0;
   localparam logic [1:0] ACT_DRAW   = 2'd1;
   localparam logic [1:0] ACT_STEP   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic REG_LINE_WIDTH = 1'b0;
   localparam logic REG_DRAW_PEN   = 1'b1;

   localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = WIDTH_BITS'(320);
   localparam logic [PEN_BITS-1:0]   DRAW_PEN_RESET   = PEN_BITS'(1);

   localparam logic signed [1:0] DIR_NONE = 2'sb00;
   localparam logic signed [1:0] DIR_POS  = 2'sb01;
   localparam logic signed [1:0] DIR_NEG  = 2'sb11;

   typedef struct packed {
      logic [1:0]            action;
      logic [COORD_BITS-1:0] target_x;
      logic [COORD_BITS-1:0] target_y;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [ADDR_BITS-1:0]  byte_address;
      logic [PEN_BITS-1:0]   pen_value;
      logic                  last_pixel;
   } rsp_type;

endpackage

// ----- rtl/core/bresenham_line_pixel_generator_unit.sv -----
// a pixel write appears on rsp in the cycle after its step request is accepted
// throughput: one request per cycle while rsp is not stalled; the pixel address is one 12x13 multiply
//    and an add between the state registers and the output register
// move, draw and idle step requests are taken and give no result
// reset (synchronous, active high) clears pen position and line state and loads
//    line_width 320 and draw_pen 1
module bresenham_line_pixel_generator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  blpg_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output blpg_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [blpg_pkg::CSR_ABITS-1:0]      csr_paddr,
   input  logic [blpg_pkg::CSR_DBITS-1:0]      csr_pwdata,
   output logic [blpg_pkg::CSR_DBITS-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import blpg_pkg::*;

   logic [WIDTH_BITS-1:0] line_width_ff;
   logic [PEN_BITS-1:0]   draw_pen_ff;

   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic [COORD_BITS-1:0] walk_x_ff, walk_x_in;
   logic [COORD_BITS-1:0] walk_y_ff, walk_y_in;
   logic [COUNT_BITS-1:0] pixels_left_ff, pixels_left_in;
   logic signed [ERR_BITS-1:0] error_term_ff, error_term_in;
   logic [COORD_BITS-1:0] major_delta_ff, major_delta_in;
   logic [COORD_BITS-1:0] minor_delta_ff, minor_delta_in;
   logic                  major_is_y_ff, major_is_y_in;
   logic signed [1:0]     dir_x_ff, dir_x_in;
   logic signed [1:0]     dir_y_ff, dir_y_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_fire;
   logic step_go;
   logic csr_write;

   logic [COORD_BITS-1:0] tx, ty;
   logic [COORD_BITS-1:0] adx, ady;
   logic                  x_lt, y_lt;
   logic [COORD_BITS-1:0] setup_major, setup_minor;
   logic [WIDTH_BITS+COORD_BITS-1:0] row_offset;
   logic [COUNT_BITS-1:0] pixels_dec;

   function automatic logic [COORD_BITS-1:0] move_coord(
      input logic [COORD_BITS-1:0] c,
      input logic signed [1:0]     d
   );
      logic [COORD_BITS-1:0] r;
      r = c;
      if (d == DIR_POS) begin
         r = c + COORD_BITS'(1);
      end else if (d == DIR_NEG) begin
         r = c - COORD_BITS'(1);
      end
      return r;
   endfunction

   // output register frees when empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign step_go   = req_fire && (req_data.action == ACT_STEP) && (pixels_left_ff != '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_LINE_WIDTH) begin
         csr_prdata = CSR_DBITS'(line_width_ff);
      end else begin
         csr_prdata = CSR_DBITS'(draw_pen_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         draw_pen_ff   <= DRAW_PEN_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_LINE_WIDTH) begin
            line_width_ff <= csr_pwdata[WIDTH_BITS-1:0];
         end else begin
            draw_pen_ff <= csr_pwdata[PEN_BITS-1:0];
         end
      end
   end

   // line setup terms
   assign tx   = req_data.target_x;
   assign ty   = req_data.target_y;
   assign x_lt = pos_x_ff < tx;
   assign y_lt = pos_y_ff < ty;
   assign adx  = x_lt ? (tx - pos_x_ff) : (pos_x_ff - tx);
   assign ady  = y_lt ? (ty - pos_y_ff) : (pos_y_ff - ty);

   always_comb begin
      if (pos_y_ff == ty) begin
         setup_major = adx;
         setup_minor = '0;
      end else if (pos_x_ff == tx) begin
         setup_major = ady;
         setup_minor = '0;
      end else if (ady > adx) begin
         setup_major = ady;
         setup_minor = adx;
      end else begin
         setup_major = adx;
         setup_minor = ady;
      end
   end

   assign row_offset = walk_y_ff * line_width_ff;
   assign pixels_dec = pixels_left_ff - COUNT_BITS'(1);

   always_comb begin
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      walk_x_in      = walk_x_ff;
      walk_y_in      = walk_y_ff;
      pixels_left_in = pixels_left_ff;
      error_term_in  = error_term_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      major_is_y_in  = major_is_y_ff;
      dir_x_in       = dir_x_ff;
      dir_y_in       = dir_y_ff;

      rsp_data_in.pixel_x      = walk_x_ff;
      rsp_data_in.pixel_y      = walk_y_ff;
      rsp_data_in.byte_address = row_offset[ADDR_BITS-1:0] + ADDR_BITS'(walk_x_ff);
      rsp_data_in.pen_value    = draw_pen_ff;
      rsp_data_in.last_pixel   = (pixels_dec == '0);

      if (req_fire) begin
         case (req_data.action)
            ACT_MOVE: begin
               pos_x_in       = tx;
               pos_y_in       = ty;
               pixels_left_in = '0;
            end
            ACT_DRAW: begin
               pos_x_in       = tx;
               pos_y_in       = ty;
               walk_x_in      = pos_x_ff;
               walk_y_in      = pos_y_ff;
               major_delta_in = setup_major;
               minor_delta_in = setup_minor;
               pixels_left_in = COUNT_BITS'(setup_major);
               error_term_in  = $signed({2'b00, setup_minor, 1'b0})
                              - $signed({3'b000, setup_major});
               if (pos_y_ff == ty) begin
                  // horizontal: walk upward from the smaller x
                  walk_x_in     = x_lt ? pos_x_ff : tx;
                  major_is_y_in = 1'b0;
                  dir_x_in      = DIR_POS;
                  dir_y_in      = DIR_NONE;
               end else if (pos_x_ff == tx) begin
                  walk_y_in     = y_lt ? pos_y_ff : ty;
                  major_is_y_in = 1'b1;
                  dir_x_in      = DIR_NONE;
                  dir_y_in      = DIR_POS;
               end else begin
                  major_is_y_in = ady > adx;
                  dir_x_in      = x_lt ? DIR_POS : DIR_NEG;
                  dir_y_in      = y_lt ? DIR_POS : DIR_NEG;
               end
            end
            ACT_STEP: begin
               if (step_go) begin
                  pixels_left_in = pixels_dec;
                  error_term_in  = error_term_ff + $signed({2'b00, minor_delta_ff, 1'b0});
                  if (!error_term_ff[ERR_BITS-1]) begin
                     error_term_in = error_term_ff
                                   + $signed({2'b00, minor_delta_ff, 1'b0})
                                   - $signed({2'b00, major_delta_ff, 1'b0});
                  end
                  if (major_is_y_ff) begin
                     walk_y_in = move_coord(walk_y_ff, dir_y_ff);
                     if (!error_term_ff[ERR_BITS-1]) begin
                        walk_x_in = move_coord(walk_x_ff, dir_x_ff);
                     end
                  end else begin
                     walk_x_in = move_coord(walk_x_ff, dir_x_ff);
                     if (!error_term_ff[ERR_BITS-1]) begin
                        walk_y_in = move_coord(walk_y_ff, dir_y_ff);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         walk_x_ff      <= '0;
         walk_y_ff      <= '0;
         pixels_left_ff <= '0;
         error_term_ff  <= '0;
         major_delta_ff <= '0;
         minor_delta_ff <= '0;
         major_is_y_ff  <= 1'b0;
         dir_x_ff       <= DIR_NONE;
         dir_y_ff       <= DIR_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         walk_x_ff      <= walk_x_in;
         walk_y_ff      <= walk_y_in;
         pixels_left_ff <= pixels_left_in;
         error_term_ff  <= error_term_in;
         major_delta_ff <= major_delta_in;
         minor_delta_ff <= minor_delta_in;
         major_is_y_ff  <= major_is_y_in;
         dir_x_ff       <= dir_x_in;
         dir_y_ff       <= dir_y_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // the final step of a line empties the counter and flags its pixel
   assert property (@(posedge clock) disable iff (reset)
      (step_go && pixels_left_ff == COUNT_BITS'(1))
      |=> (pixels_left_ff == '0 && rsp_valid_ff && rsp_data_ff.last_pixel))
      else $error("last pixel not flagged or count not cleared");

   // remaining count never exceeds the line length
   assert property (@(posedge clock) disable iff (reset)
      pixels_left_ff <= COUNT_BITS'(major_delta_ff))
      else $error("pixel count above line length");

   // axis-aligned lines carry no minor slope
   assert property (@(posedge clock) disable iff (reset)
      (pixels_left_ff != '0 && (dir_x_ff == DIR_NONE || dir_y_ff == DIR_NONE))
      |-> (minor_delta_ff == '0))
      else $error("axis-aligned line with minor slope");

endmodule
